// ===== src/mra_pkg.sv =====
// Shared types and codes for the mouse report accumulator.
// Depends on nothing; every other file in src refers to it by scoped names.
package mra_pkg;

	localparam int unsigned CoordW = 12;
	localparam int unsigned SizeW  = 13;
	localparam int unsigned CfgW   = 13;

	localparam logic [1:0] OP_REPORT  = 2'd0;
	localparam logic [1:0] OP_SET_POS = 2'd1;
	localparam logic [1:0] OP_FETCH   = 2'd2;

	localparam logic [1:0] MODE_POLL    = 2'd0;
	localparam logic [1:0] MODE_HANDLER = 2'd1;
	localparam logic [1:0] MODE_FORWARD = 2'd2;

	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DELIVERY_MODE = 2'd2;
	localparam logic [1:0] REG_MOVE_EVENTS   = 2'd3;

	localparam logic [SizeW-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [SizeW-1:0] RESET_HEIGHT = 13'd480;

	typedef struct packed {
		logic [1:0]        operation;
		logic [7:0]        report_buttons;
		logic signed [7:0] report_dx;
		logic signed [7:0] report_dy;
		logic signed [7:0] report_wheel;
		logic signed [7:0] report_pan;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
	} item_t;

	typedef struct packed {
		logic [CoordW-1:0] pos_x;
		logic [CoordW-1:0] pos_y;
		logic [7:0]        buttons_now;
		logic [7:0]        toggled_mask;
		logic signed [7:0] wheel_total;
		logic signed [7:0] pan_total;
		logic              event_pending;
		logic              event_signal;
		logic              report_forward;
	} result_t;

	typedef struct packed {
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
		logic [7:0]        buttons;
		logic [7:0]        toggled;
		logic [7:0]        wheel;
		logic [7:0]        pan;
		logic              pending;
	} state_t;

	typedef struct packed {
		logic [SizeW-1:0] screen_width;
		logic [SizeW-1:0] screen_height;
		logic [1:0]       delivery_mode;
		logic             move_events_enabled;
	} cfg_t;

endpackage

// ===== src/mra_clamp.sv =====
// Clamps one signed coordinate to the range zero to screen size minus one.
// Depends on mra_pkg for the coordinate and size widths.
module mra_clamp (
	input  logic signed [16:0]               value,
	input  logic [mra_pkg::SizeW-1:0]        size,
	output logic [mra_pkg::CoordW-1:0]       coord
);

	logic [mra_pkg::SizeW-1:0]  size_lim;
	logic [mra_pkg::CoordW-1:0] top;

	always_comb begin
		// Sizes beyond the 4096 pixel coordinate space act as 4096.
		size_lim = (size > 13'd4096) ? 13'd4096 : size;
		top      = mra_pkg::CoordW'(size_lim - 13'd1);
		if (size == '0) begin
			coord = '0;
		end else if (value < 0) begin
			coord = '0;
		end else if (value > $signed({5'b0, top})) begin
			coord = top;
		end else begin
			coord = value[mra_pkg::CoordW-1:0];
		end
	end

endmodule

// ===== src/mra_update.sv =====
// Next-state and result logic for one request applied to the mouse state.
// Depends on mra_pkg and instantiates mra_clamp for each axis.
module mra_update (
	input  mra_pkg::item_t  item,
	input  mra_pkg::state_t cur,
	input  mra_pkg::cfg_t   cfg,
	output mra_pkg::state_t nxt,
	output logic            sig,
	output logic            fwd
);

	logic [1:0]        mode;
	logic [7:0]        base_buttons;
	logic [7:0]        new_toggled;
	logic signed [16:0] x_in;
	logic signed [16:0] y_in;
	logic [mra_pkg::CoordW-1:0] x_clamped;
	logic [mra_pkg::CoordW-1:0] y_clamped;

	// Relative motion for a report, absolute target for a set position.
	always_comb begin
		if (item.operation == mra_pkg::OP_REPORT) begin
			x_in = $signed({5'b0, cur.x}) + 17'(item.report_dx);
			y_in = $signed({5'b0, cur.y}) + 17'(item.report_dy);
		end else begin
			x_in = 17'(item.new_x);
			y_in = 17'(item.new_y);
		end
	end

	mra_clamp u_clamp_x (.value(x_in), .size(cfg.screen_width),  .coord(x_clamped));
	mra_clamp u_clamp_y (.value(y_in), .size(cfg.screen_height), .coord(y_clamped));

	always_comb begin
		// The unused mode code behaves as polled mode.
		mode = (cfg.delivery_mode == mra_pkg::MODE_FORWARD ||
			cfg.delivery_mode == mra_pkg::MODE_HANDLER) ? cfg.delivery_mode
			: mra_pkg::MODE_POLL;
		// An event that was never polled has its toggles undone first.
		base_buttons = cur.pending ? (cur.buttons ^ cur.toggled) : cur.buttons;
		new_toggled  = base_buttons ^ item.report_buttons;

		nxt = cur;
		sig = 1'b0;
		fwd = 1'b0;
		case (item.operation)
			mra_pkg::OP_REPORT: begin
				nxt.toggled = new_toggled;
				nxt.buttons = item.report_buttons;
				nxt.x       = x_clamped;
				nxt.y       = y_clamped;
				nxt.wheel   = cur.wheel + item.report_wheel;
				nxt.pan     = cur.pan + item.report_pan;
				case (mode)
					mra_pkg::MODE_FORWARD: begin
						nxt.pending = 1'b0;
						fwd         = 1'b1;
					end
					mra_pkg::MODE_HANDLER: begin
						nxt.pending = 1'b0;
						sig = (new_toggled != '0) || cfg.move_events_enabled;
					end
					default: begin
						if (new_toggled != '0 || cfg.move_events_enabled) begin
							nxt.pending = 1'b1;
						end
					end
				endcase
			end
			mra_pkg::OP_SET_POS: begin
				nxt.x = x_clamped;
				nxt.y = y_clamped;
				case (mode)
					mra_pkg::MODE_FORWARD: begin
						nxt.toggled = '0;
						nxt.pending = 1'b0;
					end
					mra_pkg::MODE_HANDLER: begin
						nxt.toggled = '0;
						nxt.pending = 1'b0;
						sig         = cfg.move_events_enabled;
					end
					default: begin
						if (!cur.pending) begin
							nxt.toggled = '0;
							nxt.pending = cfg.move_events_enabled;
						end
					end
				endcase
			end
			mra_pkg::OP_FETCH: begin
				nxt.pending = 1'b0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== src/mouse_report_accumulator.sv =====
// Top level of the mouse report accumulator: request register, state, result register.
// Depends on mra_pkg and instantiates mra_update.
// An accepted request waits in the request register until the result register has room for its result.
// Throughput: one request per cycle, limited only by the result register draining.
// Reset clears the mouse state, both valid flags and loads the screen size 640 by 480,
// polled delivery and movement events off.
module mouse_report_accumulator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  mra_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output mra_pkg::result_t          result,
	input  logic                      cfg_wr_en,
	input  logic [1:0]                cfg_index,
	input  logic [mra_pkg::CfgW-1:0]  cfg_wdata
);

	// Request register: holds one accepted request until the result
	// register has room for its result.
	logic           s1_valid_q;
	mra_pkg::item_t item_s1;

	// Result register and its valid flag.
	logic             res_valid_q;
	mra_pkg::result_t result_q;

	// Architectural mouse state and configuration.
	mra_pkg::state_t state_q;
	mra_pkg::cfg_t   cfg_q;

	mra_pkg::state_t state_nxt;
	logic            sig_nxt;
	logic            fwd_nxt;
	logic            out_free;
	logic            advance;
	logic            item_acc;

	// The result register can take a new result when it is empty or is
	// being emptied at this edge. The request register in turn frees up
	// whenever it hands its request on, so both stages move every cycle
	// as long as the consumer keeps taking results.
	assign out_free   = !res_valid_q || result_ready;
	assign advance    = s1_valid_q && out_free;
	assign item_ready = !s1_valid_q || out_free;
	assign item_acc   = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_acc) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1 <= item;
		end
	end

	// All the work for a request is the short update logic between the
	// request register and the result register.
	mra_update u_update (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.sig  (sig_nxt),
		.fwd  (fwd_nxt)
	);

	// The state moves on exactly when a result is loaded, so the next
	// request in the request register sees this request's effect.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.pos_x          <= state_nxt.x;
			result_q.pos_y          <= state_nxt.y;
			result_q.buttons_now    <= state_nxt.buttons;
			result_q.toggled_mask   <= state_nxt.toggled;
			result_q.wheel_total    <= state_nxt.wheel;
			result_q.pan_total      <= state_nxt.pan;
			result_q.event_pending  <= state_nxt.pending;
			result_q.event_signal   <= sig_nxt;
			result_q.report_forward <= fwd_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// Configuration writes land directly; the port has no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width        <= mra_pkg::RESET_WIDTH;
			cfg_q.screen_height       <= mra_pkg::RESET_HEIGHT;
			cfg_q.delivery_mode       <= mra_pkg::MODE_POLL;
			cfg_q.move_events_enabled <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mra_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata;
				mra_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata;
				mra_pkg::REG_DELIVERY_MODE: cfg_q.delivery_mode <= cfg_wdata[1:0];
				mra_pkg::REG_MOVE_EVENTS:   cfg_q.move_events_enabled <= cfg_wdata[0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// A stalled input can only come from a held request.
	a_ready_needs_held: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> s1_valid_q)
		else $error("input stalled without a held request");

	// A request handed on always shows up as a valid result.
	a_advance_loads: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("request advanced but no result appeared");

	// Both handler calls never happen for the same request.
	a_one_handler: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(result_q.event_signal && result_q.report_forward))
		else $error("event and report handlers both called");

	// Forwarding a raw report always leaves no polled event pending.
	a_fwd_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_q.report_forward) |-> !result_q.event_pending)
		else $error("report forwarded with an event still pending");

	// The state holds while no result is being loaded.
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state changed without a request");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the mouse report accumulator: directed and random requests,
// a predictor of the mouse state, and a scoreboard that compares every result.
// Depends on mra_pkg and mouse_report_accumulator from src.
`timescale 1ns / 100ps

module tb_top;
	import mra_pkg::*;

	// Operation and delivery mode code three have no name in the package, but the
	// block still has to handle them.
	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int IDLE_PCT    = 32;
	localparam int CYCLE_LIMIT = 200000;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;
	logic    cfg_wr_en = 1'b0;
	logic [1:0]      cfg_index = REG_SCREEN_WIDTH;
	logic [CfgW-1:0] cfg_wdata = '0;

	// Predicted mouse state and the register copy that the predictor works from.
	state_t  mouse_model = '0;
	cfg_t    screen_cfg = '{RESET_WIDTH, RESET_HEIGHT, MODE_POLL, 1'b0};
	// Results owed by the block, oldest first.
	result_t awaited_results[$];

	int error_count = 0;
	int cycle_count = 0;
	// While no_idle is set neither side inserts random gaps.
	bit no_idle = 1'b0;
	// A hold-off request for the result side; its length is counted by the receiver.
	bit rx_hold_go = 1'b0;
	int rx_hold_cycles = 0;

	mouse_report_accumulator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Clamp one coordinate to a screen axis. A zero size pins the coordinate at zero,
	// and sizes past 4096 behave as 4096.
	function automatic logic [CoordW-1:0] clamp_axis(int coord, logic [SizeW-1:0] size);
		int top;
		if (size == 0) return '0;
		top = (size > 13'd4096) ? 4095 : int'(size) - 1;
		if (coord < 0) return '0;
		if (coord > top) return CoordW'(top);
		return CoordW'(coord);
	endfunction

	// Apply one request to the predicted mouse state and return the result it owes.
	function automatic result_t predict_mouse(item_t req);
		result_t    r;
		logic [1:0] mode;
		logic       handler_call;
		logic       forward_call;
		logic       event_due;
		mode = screen_cfg.delivery_mode;
		if (mode != MODE_HANDLER && mode != MODE_FORWARD) mode = MODE_POLL;
		handler_call = 1'b0;
		forward_call = 1'b0;
		case (req.operation)
			OP_REPORT: begin
				// An event that nobody polled is merged: its toggles are undone first.
				if (mouse_model.pending) begin
					mouse_model.buttons ^= mouse_model.toggled;
					mouse_model.toggled = '0;
				end
				mouse_model.toggled = mouse_model.buttons ^ req.report_buttons;
				mouse_model.buttons = req.report_buttons;
				mouse_model.x = clamp_axis(int'(mouse_model.x) + int'(req.report_dx),
					screen_cfg.screen_width);
				mouse_model.y = clamp_axis(int'(mouse_model.y) + int'(req.report_dy),
					screen_cfg.screen_height);
				mouse_model.wheel = mouse_model.wheel + req.report_wheel;
				mouse_model.pan = mouse_model.pan + req.report_pan;
				event_due = (mouse_model.toggled != 0) || screen_cfg.move_events_enabled;
				case (mode)
					MODE_FORWARD: begin
						mouse_model.pending = 1'b0;
						forward_call = 1'b1;
					end
					MODE_HANDLER: begin
						mouse_model.pending = 1'b0;
						handler_call = event_due;
					end
					default: begin
						if (event_due) mouse_model.pending = 1'b1;
					end
				endcase
			end
			OP_SET_POS: begin
				mouse_model.x = clamp_axis(int'(req.new_x), screen_cfg.screen_width);
				mouse_model.y = clamp_axis(int'(req.new_y), screen_cfg.screen_height);
				case (mode)
					MODE_FORWARD: begin
						mouse_model.toggled = '0;
						mouse_model.pending = 1'b0;
					end
					MODE_HANDLER: begin
						mouse_model.toggled = '0;
						mouse_model.pending = 1'b0;
						handler_call = screen_cfg.move_events_enabled;
					end
					default: begin
						// A pending polled event keeps its toggles until it is fetched.
						if (!mouse_model.pending) begin
							mouse_model.toggled = '0;
							mouse_model.pending = screen_cfg.move_events_enabled;
						end
					end
				endcase
			end
			OP_FETCH: begin
				mouse_model.pending = 1'b0;
			end
			default: begin
			end
		endcase
		r.pos_x          = mouse_model.x;
		r.pos_y          = mouse_model.y;
		r.buttons_now    = mouse_model.buttons;
		r.toggled_mask   = mouse_model.toggled;
		r.wheel_total    = mouse_model.wheel;
		r.pan_total      = mouse_model.pan;
		r.event_pending  = mouse_model.pending;
		r.event_signal   = handler_call;
		r.report_forward = forward_call;
		return r;
	endfunction

	function automatic item_t make_request(logic [1:0] op, logic [7:0] buttons, int dx, int dy,
		int wheel, int pan, int nx, int ny);
		item_t req;
		req.operation      = op;
		req.report_buttons = buttons;
		req.report_dx      = 8'(dx);
		req.report_dy      = 8'(dy);
		req.report_wheel   = 8'(wheel);
		req.report_pan     = 8'(pan);
		req.new_x          = 16'(nx);
		req.new_y          = 16'(ny);
		return req;
	endfunction

	// Screen sizes lean toward small values so that the clamps are hit often; zero and
	// sizes beyond 4096 come up now and then.
	function automatic logic [SizeW-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return SizeW'($urandom_range(4097, 8191));
			4, 5: return SizeW'($urandom_range(2, 64));
			default: return SizeW'($urandom_range(65, 4096));
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		c.screen_width        = random_size();
		c.screen_height       = random_size();
		c.delivery_mode       = 2'($urandom_range(0, 3));
		c.move_events_enabled = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// Every field starts as random noise, so fields that an operation ignores still
	// toggle. Buttons often repeat or change in one bit, as real reports do, and the
	// positions mostly land on the screen or up to 32 pixels past its edges.
	function automatic item_t random_request();
		item_t       req;
		logic [95:0] noise;
		int          pick;
		noise = {$urandom, $urandom, $urandom};
		req = noise[$bits(item_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 55) req.operation = OP_REPORT;
		else if (pick < 70) req.operation = OP_SET_POS;
		else if (pick < 93) req.operation = OP_FETCH;
		else req.operation = OP_UNUSED;
		case ($urandom_range(0, 2))
			0: req.report_buttons = mouse_model.buttons;
			1: req.report_buttons = mouse_model.buttons ^ (8'd1 << $urandom_range(0, 7));
			default: begin
			end
		endcase
		if ($urandom_range(0, 1)) begin
			req.report_dx = 8'(int'($urandom_range(0, 16)) - 8);
			req.report_dy = 8'(int'($urandom_range(0, 16)) - 8);
		end
		if ($urandom_range(0, 9) < 7) begin
			req.new_x = 16'(int'($urandom_range(0, screen_cfg.screen_width + 64)) - 32);
			req.new_y = 16'(int'($urandom_range(0, screen_cfg.screen_height + 64)) - 32);
		end
		return req;
	endfunction

	// Offer one request after an optional random gap and hold it until accepted. The
	// prediction is made right at the accepting edge, so the scoreboard never lags.
	task automatic send_request(input item_t req);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (!item_ready);
		awaited_results.push_back(predict_mouse(req));
	endtask

	// Stop offering and wait until every owed result has been taken. Every request
	// yields a result, so an empty scoreboard means the block is idle.
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (awaited_results.size() != 0) @(posedge clk);
	endtask

	// Write all four registers in index order. The narrow registers get random upper
	// bits, which the block has to ignore.
	task automatic program_config(input cfg_t c);
		logic [CfgW-1:0] data;
		for (int i = 0; i < 4; i++) begin
			data = CfgW'($urandom);
			case (2'(i))
				REG_SCREEN_WIDTH:  data = c.screen_width;
				REG_SCREEN_HEIGHT: data = c.screen_height;
				REG_DELIVERY_MODE: data = {data[CfgW-1:2], c.delivery_mode};
				default:           data = {data[CfgW-1:1], c.move_events_enabled};
			endcase
			cfg_wr_en <= 1'b1;
			cfg_index <= 2'(i);
			cfg_wdata <= data;
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		screen_cfg = c;
	endtask

	// Reset state as seen by a fetch, then the code with no operation behind it.
	task automatic test_reset_and_unused_op();
		send_request(make_request(OP_FETCH, 8'h00, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_UNUSED, 8'h5A, 3, -3, 5, -5, 77, 88));
	endtask

	// Polled mode at the reset screen size: clamps at both edges, wheel and pan wrap,
	// and a report that arrives while an earlier event is still unpolled.
	task automatic test_poll_reports();
		send_request(make_request(OP_REPORT, 8'h01, -128, -128, 0, 0, 0, 0));
		send_request(make_request(OP_REPORT, 8'h03, 10, 20, 0, 0, 0, 0));
		send_request(make_request(OP_FETCH, 8'h00, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_REPORT, 8'hFF, 127, 127, 127, -128, 0, 0));
		send_request(make_request(OP_REPORT, 8'h00, 127, 127, 1, -1, 0, 0));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 32767, 32767));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, -32768, -32768));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 100, 100));
	endtask

	// Handler mode on a zero-width, oversized-height screen with movement events on.
	task automatic test_handler_mode();
		wait_idle();
		program_config('{13'd0, 13'd8191, MODE_HANDLER, 1'b1});
		send_request(make_request(OP_REPORT, 8'h00, 127, 127, 0, 0, 0, 0));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 5000, 5000));
		send_request(make_request(OP_REPORT, 8'h81, -1, -128, 0, 0, 0, 0));
	endtask

	// Report forwarding on a one-pixel-wide screen with movement events off.
	task automatic test_forward_mode();
		wait_idle();
		program_config('{13'd1, 13'd4096, MODE_FORWARD, 1'b0});
		send_request(make_request(OP_REPORT, 8'hAA, 1, 127, 0, 0, 0, 0));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 3, 4095));
		send_request(make_request(OP_FETCH, 8'h00, 0, 0, 0, 0, 0, 0));
	endtask

	// Delivery mode three falls back to polling. A set position while an event is
	// pending must leave the toggles alone; without one it raises a movement event.
	task automatic test_odd_mode_events();
		wait_idle();
		program_config('{13'd4096, 13'd1, MODE_UNUSED, 1'b1});
		send_request(make_request(OP_REPORT, 8'hAA, 5, 5, 0, 0, 0, 0));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 4095, 0));
		send_request(make_request(OP_FETCH, 8'h00, 0, 0, 0, 0, 0, 0));
		send_request(make_request(OP_SET_POS, 8'h00, 0, 0, 0, 0, 4096, 1));
		send_request(make_request(OP_REPORT, 8'hAA, 0, 0, 0, 0, 0, 0));
	endtask

	// The result side holds off long enough for the block to fill and stall its input,
	// while the sender keeps offering. Then the sender waits for a full drain.
	task automatic test_backpressure();
		wait_idle();
		program_config(random_config());
		rx_hold_cycles = 80;
		rx_hold_go = 1'b1;
		repeat (24) send_request(random_request());
		wait_idle();
	endtask

	// Random traffic in phases, each with its own register setting. One phase runs
	// with no gaps on either side.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			wait_idle();
			program_config(random_config());
			no_idle = (phase == 3);
			repeat (110) send_request(random_request());
		end
		no_idle = 1'b0;
	endtask

	task automatic check_field(input string name, input logic signed [15:0] want,
		input logic signed [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// Result side: random stalls, or a long hold-off when the test asks for one.
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_go) begin
				rx_hold_go = 1'b0;
				result_ready <= 1'b0;
				for (int n = 0; n < rx_hold_cycles; n++) @(posedge clk);
			end else begin
				result_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Scoreboard: each taken result is matched against the oldest owed one.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (awaited_results.size() == 0) begin
				$error("result arrived with no request waiting for it");
				error_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("pos_x", 16'(want.pos_x), 16'(result.pos_x));
				check_field("pos_y", 16'(want.pos_y), 16'(result.pos_y));
				check_field("buttons_now", 16'(want.buttons_now), 16'(result.buttons_now));
				check_field("toggled_mask", 16'(want.toggled_mask),
					16'(result.toggled_mask));
				check_field("wheel_total", 16'(want.wheel_total), 16'(result.wheel_total));
				check_field("pan_total", 16'(want.pan_total), 16'(result.pan_total));
				check_field("event_pending", 16'(want.event_pending),
					16'(result.event_pending));
				check_field("event_signal", 16'(want.event_signal),
					16'(result.event_signal));
				check_field("report_forward", 16'(want.report_forward),
					16'(result.report_forward));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_top: errors");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_and_unused_op();
		test_poll_reports();
		test_handler_mode();
		test_forward_mode();
		test_odd_mode_events();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		// Waiting on past the drain catches any stray result.
		repeat (8) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/mra_pkg.sv
src/mra_clamp.sv
src/mra_update.sv
src/mouse_report_accumulator.sv
dv/tb_top.sv
